/* hdl/joystick_radial_deadzone_macros.svh */
// Assertion macros shared by the deadzone block.
`ifndef JOYSTICK_RADIAL_DEADZONE_MACROS_SVH
`define JOYSTICK_RADIAL_DEADZONE_MACROS_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define JRD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert that an antecedent implies a consequent in the next cycle.
`define JRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hdl/jrd_pkg.sv */
// Package with widths and constants of the radial deadzone block.
package jrd_pkg;
  localparam int AxisBits = 16;
  localparam int FracBits = AxisBits - 1;
  localparam int Mag2Bits = 2 * AxisBits;
  localparam int MagBits  = AxisBits + 1;
  localparam int NumBits  = AxisBits + MagBits;
  localparam int DenBits  = AxisBits + MagBits;
  localparam int SqrtSteps = Mag2Bits / 2;
  localparam int StepBits  = $clog2(SqrtSteps);
  localparam int DivSteps  = FracBits + 1;
  localparam int AddrBits  = 2;
  localparam logic [AddrBits-1:0] RegDeadzone = '0;
endpackage

/* hdl/joystick_radial_deadzone.sv */
// Top level of the rescaled radial joystick deadzone pipeline.
// Usage: raise start_i for one cycle with stick_x_i and stick_y_i; busy_o is
// always low, so a new sample can be given in every cycle. The result appears
// on out_x_o and out_y_o with done_o high for exactly one cycle, after these
// steps in order: setup stages (absolute values, squares, deadzone compare),
// 16 root steps, product forming and saturation check, 15 divider steps and
// an output register. Throughput is one sample per cycle; the latency is set
// by the one-step-per-stage square root and the two axis dividers.
// The deadzone radius is written over the APB port at byte address 0 and is
// sampled with each beat as it enters the pipeline.
// Reset clears all valid bits and sets the radius to zero; no result is
// emitted for cycles without a start beat. The receiver cannot stall, so the
// pipeline never holds; each beat simply advances one stage per cycle.
module joystick_radial_deadzone import jrd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [AddrBits-1:0]        paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic signed [AxisBits-1:0] stick_x_i,
  input  logic signed [AxisBits-1:0] stick_y_i,
  output logic                       done_o,
  output logic signed [AxisBits-1:0] out_x_o,
  output logic signed [AxisBits-1:0] out_y_o
);
`include "joystick_radial_deadzone_macros.svh"

  localparam int SqL = SqrtSteps;
  localparam int DvL = DivSteps;

  typedef struct packed {
    logic                dead;
    logic                neg_x;
    logic                neg_y;
    logic [AxisBits-1:0] ax;
    logic [AxisBits-1:0] ay;
    logic [FracBits-1:0] dz;
  } side_t;

  logic [FracBits-1:0] dz_q;
  assign pready = 1'b1;
  assign busy_o = 1'b0;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q <= '0;
    end else if (psel && penable && pwrite && paddr == RegDeadzone) begin
      dz_q <= pwdata[FracBits-1:0];
    end
  end
  assign prdata = (paddr == RegDeadzone) ? 32'(dz_q) : 32'd0;

  // Stage 1: absolute values.
  logic  v1_q;
  side_t s1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= start_i;
  end
  always_ff @(posedge clk_i) begin
    s1_q.dead  <= 1'b0;
    s1_q.neg_x <= stick_x_i[AxisBits-1];
    s1_q.neg_y <= stick_y_i[AxisBits-1];
    s1_q.ax    <= stick_x_i[AxisBits-1] ? AxisBits'(-stick_x_i) : stick_x_i;
    s1_q.ay    <= stick_y_i[AxisBits-1] ? AxisBits'(-stick_y_i) : stick_y_i;
    s1_q.dz    <= dz_q;
  end

  // Stage 2: squares of both axes and of the radius.
  logic v2_q;
  side_t s2_q;
  logic [Mag2Bits-1:0] sx_q, sy_q, sd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    s2_q <= s1_q;
    sx_q <= Mag2Bits'(s1_q.ax) * Mag2Bits'(s1_q.ax);
    sy_q <= Mag2Bits'(s1_q.ay) * Mag2Bits'(s1_q.ay);
    sd_q <= Mag2Bits'(s1_q.dz) * Mag2Bits'(s1_q.dz);
  end

  // Stage 3: squared length and deadzone test.
  logic v3_q;
  side_t s3_q;
  side_t s3_w;
  logic [Mag2Bits:0] m2_w;
  logic [Mag2Bits-1:0] m2_q;
  assign m2_w = {1'b0, sx_q} + {1'b0, sy_q};
  always_comb begin
    s3_w      = s2_q;
    s3_w.dead = (m2_w <= {1'b0, sd_q});
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    s3_q <= s3_w;
    m2_q <= m2_w[Mag2Bits-1:0];
  end

  // Square root pipeline, one result bit per stage, top bit first.
  logic                vs_q   [SqL+1];
  side_t               ss_q   [SqL+1];
  logic [Mag2Bits-1:0] rem_q  [SqL+1];
  logic [MagBits-1:0]  root_q [SqL+1];
  assign vs_q[0]   = v3_q;
  assign ss_q[0]   = s3_q;
  assign rem_q[0]  = m2_q;
  assign root_q[0] = '0;
  for (genvar k = 0; k < SqL; k++) begin : g_sqrt
    logic [Mag2Bits-1:0] rem_w;
    logic [MagBits-1:0]  root_w;
    jrd_sqrt_stage u_stage (
      .step_i (StepBits'(SqL - 1 - k)),
      .rem_i  (rem_q[k]),
      .root_i (root_q[k]),
      .rem_o  (rem_w),
      .root_o (root_w)
    );
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vs_q[k+1] <= 1'b0;
      else vs_q[k+1] <= vs_q[k];
    end
    always_ff @(posedge clk_i) begin
      ss_q[k+1]   <= ss_q[k];
      rem_q[k+1]  <= rem_w;
      root_q[k+1] <= root_w;
    end
  end

  // Products: numerators |a|*(mag-dz) and denominator (1-dz)*mag.
  logic v4_q;
  side_t s4_q;
  logic [NumBits-1:0] nx_q, ny_q;
  logic [DenBits-1:0] den_q;
  logic [MagBits-1:0] md_w;
  logic [AxisBits-1:0] od_w;
  assign md_w = root_q[SqL] - MagBits'(ss_q[SqL].dz);
  assign od_w = (AxisBits'(1) << FracBits) - AxisBits'(ss_q[SqL].dz);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else v4_q <= vs_q[SqL];
  end
  always_ff @(posedge clk_i) begin
    s4_q  <= ss_q[SqL];
    nx_q  <= NumBits'(ss_q[SqL].ax) * NumBits'(md_w);
    ny_q  <= NumBits'(ss_q[SqL].ay) * NumBits'(md_w);
    den_q <= DenBits'(od_w) * DenBits'(root_q[SqL]);
  end

  // Saturation check ahead of the divider.
  logic v5_q;
  side_t s5_q;
  logic sat_x_q, sat_y_q;
  logic [NumBits-1:0] nx5_q, ny5_q;
  logic [DenBits-1:0] den5_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    s5_q    <= s4_q;
    sat_x_q <= nx_q >= den_q;
    sat_y_q <= ny_q >= den_q;
    nx5_q   <= nx_q;
    ny5_q   <= ny_q;
    den5_q  <= den_q;
  end

  // Divider pipeline for both axes.
  logic               vd_q  [DvL];
  side_t              sd5_q [DvL];
  logic [1:0]         sat_q [DvL];
  logic [DenBits-1:0] dd_q  [DvL];
  logic [DenBits:0]   rx_q  [DvL];
  logic [DenBits:0]   ry_q  [DvL];
  logic [FracBits:0]  qx_q  [DvL];
  logic [FracBits:0]  qy_q  [DvL];
  assign vd_q[0]  = v5_q;
  assign sd5_q[0] = s5_q;
  assign sat_q[0] = {sat_y_q, sat_x_q};
  assign dd_q[0]  = den5_q;
  assign rx_q[0]  = sat_x_q ? '0 : {1'b0, nx5_q};
  assign ry_q[0]  = sat_y_q ? '0 : {1'b0, ny5_q};
  assign qx_q[0]  = '0;
  assign qy_q[0]  = '0;
  for (genvar k = 0; k < DvL - 1; k++) begin : g_div
    logic [DenBits:0]  rxw, ryw;
    logic [FracBits:0] qxw, qyw;
    jrd_div_stage u_dx (.rem_i(rx_q[k]), .den_i(dd_q[k]), .q_i(qx_q[k]),
                        .rem_o(rxw), .q_o(qxw));
    jrd_div_stage u_dy (.rem_i(ry_q[k]), .den_i(dd_q[k]), .q_i(qy_q[k]),
                        .rem_o(ryw), .q_o(qyw));
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vd_q[k+1] <= 1'b0;
      else vd_q[k+1] <= vd_q[k];
    end
    always_ff @(posedge clk_i) begin
      sd5_q[k+1] <= sd5_q[k];
      sat_q[k+1] <= sat_q[k];
      dd_q[k+1]  <= dd_q[k];
      rx_q[k+1]  <= rxw;
      ry_q[k+1]  <= ryw;
      qx_q[k+1]  <= qxw;
      qy_q[k+1]  <= qyw;
    end
  end

  // Output stage: sign, saturation and deadzone zeroing.
  logic [FracBits-1:0] fx_w, fy_w;
  logic signed [AxisBits-1:0] ox_w, oy_w;
  side_t so_w;
  assign so_w = sd5_q[DvL-1];
  assign fx_w = qx_q[DvL-1][FracBits-1:0];
  assign fy_w = qy_q[DvL-1][FracBits-1:0];
  always_comb begin
    if (so_w.dead) begin
      ox_w = '0;
    end else if (sat_q[DvL-1][0]) begin
      ox_w = so_w.neg_x ? {1'b1, {FracBits{1'b0}}} : {1'b0, {FracBits{1'b1}}};
    end else begin
      ox_w = so_w.neg_x ? AxisBits'(-{1'b0, fx_w}) : {1'b0, fx_w};
    end
    if (so_w.dead) begin
      oy_w = '0;
    end else if (sat_q[DvL-1][1]) begin
      oy_w = so_w.neg_y ? {1'b1, {FracBits{1'b0}}} : {1'b0, {FracBits{1'b1}}};
    end else begin
      oy_w = so_w.neg_y ? AxisBits'(-{1'b0, fy_w}) : {1'b0, fy_w};
    end
  end

  logic done_q;
  logic signed [AxisBits-1:0] ox_q, oy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= vd_q[DvL-1];
  end
  always_ff @(posedge clk_i) begin
    ox_q <= ox_w;
    oy_q <= oy_w;
  end
  assign done_o  = done_q;
  assign out_x_o = ox_q;
  assign out_y_o = oy_q;
  // Final remainders and the spare quotient bits are not needed downstream.
  logic unused_w;
  assign unused_w = ^{rem_q[SqL], rx_q[DvL-1], ry_q[DvL-1], dd_q[DvL-1],
                      qx_q[DvL-1][FracBits], qy_q[DvL-1][FracBits]};

  // Checks on the pipeline.
  `JRD_ASSERT_NEXT(a_start_tracked, clk_i, rst_ni, start_i, v1_q)
  `JRD_ASSERT_IMP(a_dead_zero, clk_i, rst_ni, done_o && $past(so_w.dead),
                  out_x_o == '0 && out_y_o == '0)
  `JRD_ASSERT_IMP(a_never_busy, clk_i, rst_ni, 1'b1, !busy_o)
endmodule

/* hdl/jrd_sqrt_stage.sv */
// One pipelined step of the restoring integer square root.
module jrd_sqrt_stage import jrd_pkg::*; (
  input  logic [StepBits-1:0] step_i,
  input  logic [Mag2Bits-1:0] rem_i,
  input  logic [MagBits-1:0]  root_i,
  output logic [Mag2Bits-1:0] rem_o,
  output logic [MagBits-1:0]  root_o
);
  logic [Mag2Bits+1:0] trial;
  logic [Mag2Bits+1:0] bitv;

  // Digit-by-digit root: try root*2^(k+1)+4^k against the remainder.
  always_comb begin
    bitv  = (Mag2Bits+2)'(1) << {step_i, 1'b0};
    trial = ((Mag2Bits+2)'(root_i) << ({1'b0, step_i} + 1'b1)) + bitv;
    if ({2'b00, rem_i} >= trial) begin
      rem_o  = rem_i - trial[Mag2Bits-1:0];
      root_o = root_i | (MagBits'(1) << step_i);
    end else begin
      rem_o  = rem_i;
      root_o = root_i;
    end
  end
endmodule

/* hdl/jrd_div_stage.sv */
// One pipelined step of the restoring fraction divider.
module jrd_div_stage import jrd_pkg::*; (
  input  logic [DenBits:0]   rem_i,
  input  logic [DenBits-1:0] den_i,
  input  logic [FracBits:0]  q_i,
  output logic [DenBits:0]   rem_o,
  output logic [FracBits:0]  q_o
);
  logic [DenBits+1:0] sh;

  // Shift the remainder in and subtract the divisor when it fits.
  always_comb begin
    sh = {rem_i, 1'b0};
    if (sh >= {2'b00, den_i}) begin
      rem_o = (DenBits+1)'(sh - {2'b00, den_i});
      q_o   = {q_i[FracBits-1:0], 1'b1};
    end else begin
      rem_o = sh[DenBits:0];
      q_o   = {q_i[FracBits-1:0], 1'b0};
    end
  end
endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the rescaled radial joystick deadzone block.
module tb_top;
  import jrd_pkg::*;

  localparam int PIPE_LATENCY = 37;
  localparam int ONE_LSB      = 1 << FracBits;

  typedef struct {
    logic signed [AxisBits-1:0] x;
    logic signed [AxisBits-1:0] y;
  } axes_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [AddrBits-1:0]        paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       start_i = 1'b0;
  logic                       busy_o;
  logic signed [AxisBits-1:0] stick_x_i = '0;
  logic signed [AxisBits-1:0] stick_y_i = '0;
  logic                       done_o;
  logic signed [AxisBits-1:0] out_x_o;
  logic signed [AxisBits-1:0] out_y_o;

  logic [FracBits-1:0] radius_shadow = '0;
  axes_t               pending_axes[$];
  int                  mismatches = 0;

  joystick_radial_deadzone u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start_i, .busy_o, .stick_x_i, .stick_y_i, .done_o, .out_x_o, .out_y_o
  );

  // Clock generation.
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Integer square root, truncated.
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    r = 0;
    for (int b = 17; b >= 0; b--) begin
      if (((r | (64'd1 << b)) * (r | (64'd1 << b))) <= v) r = r | (64'd1 << b);
    end
    return r;
  endfunction

  // Scales one axis by (mag - dz) / ((1 - dz) * mag) and saturates it.
  function automatic logic signed [AxisBits-1:0] scale_axis_value(
      logic signed [AxisBits-1:0] a, longint unsigned mag, longint unsigned dz);
    longint unsigned mag_a, num, den, q;
    mag_a = (a < 0) ? longint'(-longint'(a)) : longint'(a);
    num = mag_a * (mag - dz);
    den = (ONE_LSB - dz) * mag;
    q = (num >= den) ? ONE_LSB : ((num << FracBits) / den);
    if (a < 0) begin
      if (q >= ONE_LSB) return AxisBits'(-ONE_LSB);
      return AxisBits'(-longint'(q));
    end
    if (q >= ONE_LSB) return AxisBits'(ONE_LSB - 1);
    return AxisBits'(q);
  endfunction

  // Expected output pair for one sample under the current radius.
  function automatic axes_t rescale_sample(logic signed [AxisBits-1:0] x,
                                           logic signed [AxisBits-1:0] y,
                                           logic [FracBits-1:0] radius);
    axes_t r;
    longint signed xs, ys;
    longint unsigned mag2, dz, mag;
    xs = x;
    ys = y;
    dz = radius;
    mag2 = xs * xs + ys * ys;
    r.x = '0;
    r.y = '0;
    if (mag2 > dz * dz) begin
      mag = floor_root(mag2);
      r.x = scale_axis_value(x, mag, dz);
      r.y = scale_axis_value(y, mag, dz);
    end
    return r;
  endfunction

  // Tracks register writes and accepted beats; checks each result.
  always @(posedge clk_i) begin
    axes_t e;
    if (psel && penable && pwrite && pready && paddr == RegDeadzone)
      radius_shadow <= pwdata[FracBits-1:0];
    if (start_i && !busy_o)
      pending_axes = {pending_axes, rescale_sample(stick_x_i, stick_y_i, radius_shadow)};
    if (rst_ni && done_o) begin
      if (pending_axes.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d", $time, out_x_o, out_y_o);
        mismatches++;
      end else begin
        e = pending_axes.pop_front();
        if (out_x_o !== e.x) begin
          $display("%0t: out_x expected %0d actual %0d", $time, e.x, out_x_o);
          mismatches++;
        end
        if (out_y_o !== e.y) begin
          $display("%0t: out_y expected %0d actual %0d", $time, e.y, out_y_o);
          mismatches++;
        end
      end
    end
  end

  // Sends one sample and returns at the edge that accepts it.
  task automatic send_sample(logic signed [AxisBits-1:0] x, logic signed [AxisBits-1:0] y);
    start_i <= 1'b1;
    stick_x_i <= x;
    stick_y_i <= y;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
  endtask

  // Drops start for a number of cycles.
  task automatic idle_cycles(int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Waits for the pipeline to drain, then writes the radius register.
  task automatic write_radius(logic [AddrBits-1:0] addr, logic [31:0] value);
    idle_cycles(1);
    while (pending_axes.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Extremes of both axes with no deadzone and with the largest one.
  task automatic test_extremes();
    write_radius(RegDeadzone, 32'd0);
    send_sample(16'sd0, 16'sd0);
    send_sample(-16'sd32768, 16'sd0);
    send_sample(16'sd32767, 16'sd0);
    send_sample(16'sd0, -16'sd32768);
    send_sample(-16'sd32768, -16'sd32768);
    send_sample(16'sd32767, 16'sd32767);
    send_sample(16'sd1, -16'sd1);
    send_sample(-16'sd1, 16'sd0);
    write_radius(RegDeadzone, 32'd32767);
    send_sample(16'sd32767, 16'sd0);
    send_sample(-16'sd32768, 16'sd0);
    send_sample(-16'sd32768, -16'sd32768);
    send_sample(16'sd32767, -16'sd32768);
  endtask

  // Samples on and around the deadzone circle, including upper value bits.
  task automatic test_deadzone_edge();
    write_radius(RegDeadzone, 32'd1000);
    send_sample(16'sd1000, 16'sd0);
    send_sample(16'sd1001, 16'sd0);
    send_sample(16'sd0, -16'sd1000);
    send_sample(16'sd600, 16'sd800);
    send_sample(-16'sd600, 16'sd801);
    send_sample(16'sd999, 16'sd0);
    write_radius(RegDeadzone, 32'hFFFF_8005);
    send_sample(16'sd5, 16'sd0);
    send_sample(16'sd6, 16'sd0);
    send_sample(-16'sd4, -16'sd4);
    send_sample(-16'sd32768, 16'sd7);
  endtask

  // Random samples in bursts, half of them near the deadzone circle.
  task automatic test_random_sweep(logic [31:0] radius, int count);
    int burst, r;
    logic signed [AxisBits-1:0] x, y;
    write_radius(RegDeadzone, radius);
    burst = 0;
    for (int i = 0; i < count; i++) begin
      r = radius[FracBits-1:0];
      if ($urandom_range(0, 1) == 0) begin
        x = AxisBits'($urandom);
        y = AxisBits'($urandom);
      end else begin
        x = AxisBits'($urandom_range(0, r + 64 > 32767 ? 32767 : r + 64));
        y = AxisBits'($urandom_range(0, r + 64 > 32767 ? 32767 : r + 64));
        if ($urandom_range(0, 1)) x = -x;
        if ($urandom_range(0, 1)) y = -y;
      end
      if (burst == 0) begin
        if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
        burst = $urandom_range(1, 40);
      end
      send_sample(x, y);
      burst--;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_deadzone_edge();
    test_random_sweep(32'd0, 275);
    test_random_sweep(32'd32767, 275);
    test_random_sweep(32'd1, 275);
    test_random_sweep($urandom_range(1, 32766), 275);
    test_random_sweep($urandom_range(16000, 32766), 275);
    test_random_sweep($urandom, 275);
    idle_cycles(1);
    while (pending_axes.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[joystick_radial_deadzone] OK");
    end else begin
      $display("[joystick_radial_deadzone] ERROR");
    end
    $finish;
  end

  // Guards against a hung run.
  initial begin
    #400000;
    $display("[joystick_radial_deadzone] ERROR");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/jrd_pkg.sv
hdl/jrd_sqrt_stage.sv
hdl/jrd_div_stage.sv
hdl/joystick_radial_deadzone.sv
verif/tb_top.sv
